[rtl/cms_pkg.sv]
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, widths, register codes and constant tables for the
// channel mean subtract pipeline.
// ----------------------------------------------------------------------------
package cms_pkg;

    // lane and channel limits
    localparam int LANES        = 8;
    localparam int MAX_CHANNELS = 8;

    // datapath widths
    localparam int SAMPLE_W  = 24;   // one sample
    localparam int SUM_W     = 27;   // signed sum of up to eight samples
    localparam int MAG_W     = 27;   // magnitude of the sum
    localparam int RECIP_W   = 32;   // reciprocal scale, 2^32 / n rounded up
    localparam int PROD_W    = MAG_W + RECIP_W;
    localparam int DIFF_W    = 28;   // lane result before clamping
    localparam int CNT_W     = 4;    // channel count register
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 4;

    // input transfer to result strobe, in clock cycles
    localparam int LATENCY = 8;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic [CNT_W-1:0]           t_count;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_COUNT = 1'b0,
        REG_SAMPLE_FORMAT = 1'b1
    } t_cfg_reg;

    // clamp limits for the two sample formats
    localparam t_diff MAX16 = t_diff'(32'sh0000_7fff);
    localparam t_diff MIN16 = -t_diff'(32'sh0000_8000);
    localparam t_diff MAX24 = t_diff'(32'sh007f_ffff);
    localparam t_diff MIN24 = -t_diff'(32'sh0080_0000);

    localparam t_count MIN_COUNT   = t_count'(2);
    localparam t_count COUNT_RESET = t_count'(2);

    // limit a written channel count to the supported range
    function automatic t_count eff_count(input logic [CFG_DATA_W-1:0] raw);
        t_count n;
        n = t_count'(raw);
        if (n < MIN_COUNT) begin
            n = MIN_COUNT;
        end else if (n > t_count'(MAX_CHANNELS)) begin
            n = t_count'(MAX_CHANNELS);
        end
        return n;
    endfunction

    // ceil(2^32 / n): exact floor quotient for magnitudes below 2^27
    function automatic logic [RECIP_W-1:0] recip(input t_count n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd2:    r = 32'h8000_0000;
            4'd3:    r = 32'h5555_5556;
            4'd4:    r = 32'h4000_0000;
            4'd5:    r = 32'h3333_3334;
            4'd6:    r = 32'h2AAA_AAAB;
            4'd7:    r = 32'h2492_4925;
            4'd8:    r = 32'h2000_0000;
            default: r = 32'h8000_0000;
        endcase
        return r;
    endfunction

endpackage

[rtl/channel_mean_subtract.sv]
// ----------------------------------------------------------------------------
// channel_mean_subtract
// Removes the frame mean from each active channel of a multichannel audio
// frame, truncating toward zero, and clamps to the 16-bit or 24-bit range.
// ----------------------------------------------------------------------------
//
//  Channel   | Handshake             | Payload
//  ----------+-----------------------+-----------------------------------
//  input     | start, busy           | i_in_ch0 .. i_in_ch7 (24b signed)
//  result    | o_strobe              | o_out_ch0 .. o_out_ch7 (24b signed)
//  config    | i_cfg_we              | i_cfg_idx, i_cfg_data
//
//  One frame enters per clock while busy is low; each frame passes through
//  the eight register stages of the pipeline (capture, sum, magnitude,
//  reciprocal multiply, remainder check, floor, lane difference, clamp) to
//  its result strobe. busy is high only while i_rst_n is low. Reset is
//  synchronous and clears the valid chain and the configuration. The
//  pipeline never stalls.
//
module channel_mean_subtract (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  cms_pkg::t_sample                     i_in_ch0,
    input  cms_pkg::t_sample                     i_in_ch1,
    input  cms_pkg::t_sample                     i_in_ch2,
    input  cms_pkg::t_sample                     i_in_ch3,
    input  cms_pkg::t_sample                     i_in_ch4,
    input  cms_pkg::t_sample                     i_in_ch5,
    input  cms_pkg::t_sample                     i_in_ch6,
    input  cms_pkg::t_sample                     i_in_ch7,
    output logic                                 o_strobe,
    output cms_pkg::t_sample                     o_out_ch0,
    output cms_pkg::t_sample                     o_out_ch1,
    output cms_pkg::t_sample                     o_out_ch2,
    output cms_pkg::t_sample                     o_out_ch3,
    output cms_pkg::t_sample                     o_out_ch4,
    output cms_pkg::t_sample                     o_out_ch5,
    output cms_pkg::t_sample                     o_out_ch6,
    output cms_pkg::t_sample                     o_out_ch7,
    input  logic                                 i_cfg_we,
    input  logic [cms_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cms_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // configuration
    cms_pkg::t_count r_chan_n;
    logic            r_fmt;

    // input frame
    cms_pkg::t_sample in_x [cms_pkg::LANES];

    // valid chain and sample copies
    logic             r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    cms_pkg::t_sample r_x1 [cms_pkg::LANES];
    cms_pkg::t_sample r_x2 [cms_pkg::LANES];
    cms_pkg::t_sample r_x3 [cms_pkg::LANES];
    cms_pkg::t_sample r_x4 [cms_pkg::LANES];
    cms_pkg::t_sample r_x5 [cms_pkg::LANES];
    cms_pkg::t_sample r_x6 [cms_pkg::LANES];

    // sum, magnitude and quotient path
    cms_pkg::t_sum                  n_sum;
    cms_pkg::t_sum                  r_sum2;
    logic [cms_pkg::MAG_W-1:0]      r_mag3, r_mag4;
    logic                           r_neg3, r_neg4, r_neg5;
    logic [cms_pkg::PROD_W-1:0]     r_prod4;
    logic [cms_pkg::MAG_W-1:0]      q5;
    logic [cms_pkg::MAG_W+cms_pkg::CNT_W-1:0] qn5;
    logic [cms_pkg::MAG_W-1:0]      r_q5;
    logic                           r_rz5, r_rz6;
    cms_pkg::t_sum                  qs6;
    cms_pkg::t_sum                  r_qs6;

    // lane results
    cms_pkg::t_diff   n_a     [cms_pkg::LANES];
    cms_pkg::t_diff   n_am1   [cms_pkg::LANES];
    cms_pkg::t_diff   r_d7    [cms_pkg::LANES];
    cms_pkg::t_diff   hi_lim, lo_lim;
    cms_pkg::t_sample r_out8  [cms_pkg::LANES];

    assign busy = ~i_rst_n;

    assign in_x[0] = i_in_ch0;
    assign in_x[1] = i_in_ch1;
    assign in_x[2] = i_in_ch2;
    assign in_x[3] = i_in_ch3;
    assign in_x[4] = i_in_ch4;
    assign in_x[5] = i_in_ch5;
    assign in_x[6] = i_in_ch6;
    assign in_x[7] = i_in_ch7;

    // hold configuration, store the channel count already limited
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_n <= cms_pkg::COUNT_RESET;
            r_fmt    <= 1'b0;
        end else if (i_cfg_we) begin
            case (cms_pkg::t_cfg_reg'(i_cfg_idx))
                cms_pkg::REG_CHANNEL_COUNT: r_chan_n <= cms_pkg::eff_count(i_cfg_data);
                cms_pkg::REG_SAMPLE_FORMAT: r_fmt    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else begin
            r_v1 <= start & ~busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    // sum the active lanes
    always_comb begin
        n_sum = '0;
        for (int i = 0; i < cms_pkg::LANES; i++) begin
            if (cms_pkg::CNT_W'(i) < r_chan_n) begin
                n_sum = n_sum + cms_pkg::t_sum'(r_x1[i]);
            end
        end
    end

    // floor quotient of the magnitude and its remainder check
    assign q5  = r_prod4[cms_pkg::PROD_W-1:cms_pkg::RECIP_W];
    assign qn5 = q5 * r_chan_n;

    // floor quotient of the magnitude as a signed value
    assign qs6 = $signed(r_q5);

    // per lane: a = x - floor(sum/n); step down by one when the
    // remainder is nonzero and a is positive
    always_comb begin
        for (int i = 0; i < cms_pkg::LANES; i++) begin
            n_a[i]   = cms_pkg::t_diff'(r_x6[i]) - cms_pkg::t_diff'(r_qs6);
            n_am1[i] = cms_pkg::t_diff'(r_x6[i]) + cms_pkg::t_diff'(~r_qs6);
        end
    end

    assign hi_lim = r_fmt ? cms_pkg::MAX24 : cms_pkg::MAX16;
    assign lo_lim = r_fmt ? cms_pkg::MIN24 : cms_pkg::MIN16;

    // pipeline payload registers
    always_ff @(posedge i_clk) begin
        // stage 1: capture the frame
        r_x1 <= in_x;
        // stage 2: sum
        r_x2   <= r_x1;
        r_sum2 <= n_sum;
        // stage 3: magnitude and sign
        r_x3   <= r_x2;
        r_neg3 <= r_sum2[cms_pkg::SUM_W-1];
        r_mag3 <= cms_pkg::MAG_W'(r_sum2[cms_pkg::SUM_W-1] ? -r_sum2 : r_sum2);
        // stage 4: multiply by the reciprocal
        r_x4    <= r_x3;
        r_neg4  <= r_neg3;
        r_mag4  <= r_mag3;
        r_prod4 <= cms_pkg::PROD_W'(r_mag3) * cms_pkg::PROD_W'(cms_pkg::recip(r_chan_n));
        // stage 5: quotient and zero-remainder flag
        r_x5   <= r_x4;
        r_neg5 <= r_neg4;
        r_q5   <= q5;
        r_rz5  <= (qn5[cms_pkg::MAG_W-1:0] == r_mag4);
        // stage 6: signed floor quotient
        r_x6  <= r_x5;
        r_rz6 <= r_rz5;
        r_qs6 <= r_neg5 ? (r_rz5 ? -qs6 : ~qs6) : qs6;
        // stage 7: lane difference truncated toward zero
        for (int i = 0; i < cms_pkg::LANES; i++) begin
            if (!r_rz6 && !n_a[i][cms_pkg::DIFF_W-1] && (n_a[i] != '0)) begin
                r_d7[i] <= n_am1[i];
            end else begin
                r_d7[i] <= n_a[i];
            end
        end
        // stage 8: clamp and drop inactive lanes
        for (int i = 0; i < cms_pkg::LANES; i++) begin
            if (cms_pkg::CNT_W'(i) >= r_chan_n) begin
                r_out8[i] <= '0;
            end else if (r_d7[i] >= hi_lim) begin
                r_out8[i] <= hi_lim[cms_pkg::SAMPLE_W-1:0];
            end else if (r_d7[i] <= lo_lim) begin
                r_out8[i] <= lo_lim[cms_pkg::SAMPLE_W-1:0];
            end else begin
                r_out8[i] <= r_d7[i][cms_pkg::SAMPLE_W-1:0];
            end
        end
    end

    assign o_strobe  = r_v8;
    assign o_out_ch0 = r_out8[0];
    assign o_out_ch1 = r_out8[1];
    assign o_out_ch2 = r_out8[2];
    assign o_out_ch3 = r_out8[3];
    assign o_out_ch4 = r_out8[4];
    assign o_out_ch5 = r_out8[5];
    assign o_out_ch6 = r_out8[6];
    assign o_out_ch7 = r_out8[7];

    // every transfer gives a result a fixed latency later
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(cms_pkg::LATENCY) o_strobe)
        else $error("result strobe missing after input transfer");

    // lane 7 is inactive unless all eight channels are in use
    a_lane7_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_chan_n < cms_pkg::t_count'(cms_pkg::MAX_CHANNELS)))
        |-> (o_out_ch7 == '0))
        else $error("inactive lane 7 carries data");

    // 16-bit format keeps lane 0 results inside the 16-bit range
    a_fmt16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !r_fmt) |->
        ((o_out_ch0[23:15] == '0) || (o_out_ch0[23:15] == '1)))
        else $error("16-bit result out of range");

    // the floor quotient times the channel count never exceeds the magnitude it came from
    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (qn5[cms_pkg::MAG_W+cms_pkg::CNT_W-1:0]
                  <= (cms_pkg::MAG_W+cms_pkg::CNT_W)'(r_mag4)))
        else $error("quotient times count exceeds sum magnitude");

endmodule

[bench/mean_subtract_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mean_subtract_checker
// Watches the frame, result and register ports of channel_mean_subtract,
// predicts each centered frame from its own copy of the registers and
// compares every result, lane by lane, with the oldest prediction.
// ----------------------------------------------------------------------------
module mean_subtract_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  cms_pkg::t_sample                 i_in_ch0,
    input  cms_pkg::t_sample                 i_in_ch1,
    input  cms_pkg::t_sample                 i_in_ch2,
    input  cms_pkg::t_sample                 i_in_ch3,
    input  cms_pkg::t_sample                 i_in_ch4,
    input  cms_pkg::t_sample                 i_in_ch5,
    input  cms_pkg::t_sample                 i_in_ch6,
    input  cms_pkg::t_sample                 i_in_ch7,
    input  logic                             i_strobe,
    input  cms_pkg::t_sample                 i_res_ch0,
    input  cms_pkg::t_sample                 i_res_ch1,
    input  cms_pkg::t_sample                 i_res_ch2,
    input  cms_pkg::t_sample                 i_res_ch3,
    input  cms_pkg::t_sample                 i_res_ch4,
    input  cms_pkg::t_sample                 i_res_ch5,
    input  cms_pkg::t_sample                 i_res_ch6,
    input  cms_pkg::t_sample                 i_res_ch7,
    input  logic                             i_cfg_we,
    input  logic [cms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_mismatch_count,
    output int                               o_pending
);
    import cms_pkg::*;

    typedef t_sample [LANES-1:0] t_lanes;

    t_lanes             centered_frames [$];
    logic [CNT_W-1:0]   count_reg = COUNT_RESET;
    logic               format_reg = 1'b0;
    t_lanes             frame_in;
    t_lanes             frame_out;

    assign frame_in  = {i_in_ch7, i_in_ch6, i_in_ch5, i_in_ch4,
                        i_in_ch3, i_in_ch2, i_in_ch1, i_in_ch0};
    assign frame_out = {i_res_ch7, i_res_ch6, i_res_ch5, i_res_ch4,
                        i_res_ch3, i_res_ch2, i_res_ch1, i_res_ch0};

    initial begin
        o_mismatch_count = 0;
        o_pending        = 0;
    end

    // subtract the frame mean from each active lane, truncate, then clamp
    function automatic t_lanes center_frame(t_lanes smp, logic [CNT_W-1:0] cnt,
                                            logic fmt);
        longint n;
        longint hi;
        longint lo;
        longint total;
        longint r;
        int     i;
        t_lanes res;
        n = longint'(cnt);
        if (n < 2) begin
            n = 2;
        end else if (n > MAX_CHANNELS) begin
            n = MAX_CHANNELS;
        end
        hi = fmt ? longint'(MAX24) : longint'(MAX16);
        lo = fmt ? longint'(MIN24) : longint'(MIN16);
        total = 0;
        for (i = 0; i < n; i++) begin
            total += longint'($signed(smp[i]));
        end
        for (i = 0; i < LANES; i++) begin
            r = 0;
            if (i < n) begin
                r = (longint'($signed(smp[i])) * n - total) / n;
                if (r >= hi) begin
                    r = hi;
                end else if (r <= lo) begin
                    r = lo;
                end
            end
            res[i] = t_sample'(r);
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lanes want;
        int     i;
        if (!i_rst_n) begin
            count_reg  <= COUNT_RESET;
            format_reg <= 1'b0;
        end else begin
            // match each result against the oldest prediction
            if (i_strobe) begin
                if (centered_frames.size() == 0) begin
                    $error("result with no frame outstanding");
                    o_mismatch_count <= o_mismatch_count + 1;
                end else begin
                    want = centered_frames.pop_front();
                    if (want != frame_out) begin
                        o_mismatch_count <= o_mismatch_count + 1;
                        for (i = 0; i < LANES; i++) begin
                            if (want[i] != frame_out[i]) begin
                                $error("out_ch%0d: expected %0d, actual %0d", i,
                                       $signed(want[i]), $signed(frame_out[i]));
                            end
                        end
                    end
                end
            end
            // predict on every frame transfer, with the registers in force now
            if (i_start && !i_busy) begin
                centered_frames.push_back(center_frame(frame_in, count_reg,
                                                       format_reg));
            end
            // track register writes after the prediction of this edge
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CHANNEL_COUNT) begin
                    count_reg <= i_cfg_data;
                end else if (i_cfg_idx == REG_SAMPLE_FORMAT) begin
                    format_reg <= i_cfg_data[0];
                end
            end
        end
        o_pending <= centered_frames.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives channel_mean_subtract with directed corner frames and then random
// frames under many channel count and format settings, with random gaps.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import cms_pkg::*;

    typedef t_sample [LANES-1:0] t_lanes;

    localparam int      WATCHDOG_LIMIT = 500;
    localparam int      NUM_PHASES     = 14;
    localparam int      PHASE_FRAMES   = 132;
    localparam t_sample SMP_MAX24      = t_sample'(MAX24);
    localparam t_sample SMP_MIN24      = t_sample'(MIN24);
    localparam t_sample SMP_MAX16      = t_sample'(MAX16);
    localparam t_sample SMP_MIN16      = t_sample'(MIN16);

    // register settings per random phase; counts cover both clamped ends
    logic [CFG_DATA_W-1:0] count_plan [NUM_PHASES] =
        '{4'd2, 4'd8, 4'd0, 4'd5, 4'd15, 4'd3, 4'd1, 4'd8, 4'd4, 4'd9, 4'd6,
          4'd7, 4'd2, 4'd8};
    logic [CFG_DATA_W-1:0] format_plan [NUM_PHASES] =
        '{4'd0, 4'd1, 4'd1, 4'd0, 4'd1, 4'd14, 4'd0, 4'd15, 4'd1, 4'd0, 4'd1,
          4'd2, 4'd1, 4'd0};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    t_lanes                 frame = '0;
    logic                   o_strobe;
    t_lanes                 result;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    int                     mismatch_count;
    int                     pending;
    int                     idle_cycles = 0;
    logic                   burst = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    channel_mean_subtract dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in_ch0   (frame[0]),
        .i_in_ch1   (frame[1]),
        .i_in_ch2   (frame[2]),
        .i_in_ch3   (frame[3]),
        .i_in_ch4   (frame[4]),
        .i_in_ch5   (frame[5]),
        .i_in_ch6   (frame[6]),
        .i_in_ch7   (frame[7]),
        .o_strobe   (o_strobe),
        .o_out_ch0  (result[0]),
        .o_out_ch1  (result[1]),
        .o_out_ch2  (result[2]),
        .o_out_ch3  (result[3]),
        .o_out_ch4  (result[4]),
        .o_out_ch5  (result[5]),
        .o_out_ch6  (result[6]),
        .o_out_ch7  (result[7]),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    mean_subtract_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_in_ch0         (frame[0]),
        .i_in_ch1         (frame[1]),
        .i_in_ch2         (frame[2]),
        .i_in_ch3         (frame[3]),
        .i_in_ch4         (frame[4]),
        .i_in_ch5         (frame[5]),
        .i_in_ch6         (frame[6]),
        .i_in_ch7         (frame[7]),
        .i_strobe         (o_strobe),
        .i_res_ch0        (result[0]),
        .i_res_ch1        (result[1]),
        .i_res_ch2        (result[2]),
        .i_res_ch3        (result[3]),
        .i_res_ch4        (result[4]),
        .i_res_ch5        (result[5]),
        .i_res_ch6        (result[6]),
        .i_res_ch7        (result[7]),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    // end the run when nothing has moved for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // even lanes get a, odd lanes get b
    function automatic t_lanes lanes_of(t_sample a, t_sample b);
        t_lanes v;
        for (int i = 0; i < LANES; i++) begin
            v[i] = i[0] ? b : a;
        end
        return v;
    endfunction

    function automatic t_sample rand_sample();
        logic signed [15:0] half;
        half = 16'($urandom);
        case ($urandom_range(0, 7))
            0, 1, 2: return t_sample'($urandom);
            3, 4:    return t_sample'(half);
            5:       return $urandom_range(0, 1) ? SMP_MAX24 : SMP_MIN24;
            6:       return $urandom_range(0, 1) ? SMP_MAX16 : SMP_MIN16;
            default: return t_sample'($signed($urandom_range(0, 8)) - 4);
        endcase
    endfunction

    // mostly independent lanes; some lanes sit near a common level
    function automatic t_lanes rand_frame();
        t_lanes  v;
        t_sample base;
        base = rand_sample();
        for (int i = 0; i < LANES; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                v[i] = base + t_sample'($signed($urandom_range(0, 64)) - 32);
            end else begin
                v[i] = rand_sample();
            end
        end
        return v;
    endfunction

    // present one frame after a random gap, or none in a burst, and hold it until its transfer
    task automatic send_frame(t_lanes v);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        frame <= v;
        do @(posedge i_clk); while (busy);
    endtask

    // drop start and let every outstanding result arrive
    task automatic wait_idle();
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        t_lanes one_out;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two channels, 16-bit range: extremes, truncation, wide inputs
        send_frame(lanes_of('0, '0));
        send_frame(lanes_of(SMP_MAX24, SMP_MAX24));
        send_frame(lanes_of(SMP_MIN24, SMP_MIN24));
        send_frame(lanes_of(SMP_MAX24, SMP_MIN24));
        send_frame(lanes_of(SMP_MIN24, SMP_MAX24));
        send_frame(lanes_of(24'sd3, 24'sd0));
        send_frame(lanes_of(-24'sd3, 24'sd0));
        send_frame(lanes_of(SMP_MAX16, SMP_MIN16));
        send_frame(lanes_of(24'sh004000, -24'sh004000));

        // eight channels, 24-bit range: clamp both ways
        write_reg(REG_SAMPLE_FORMAT, 4'd1);
        write_reg(REG_CHANNEL_COUNT, 4'd8);
        send_frame(lanes_of(SMP_MAX24, SMP_MIN24));
        send_frame(lanes_of(SMP_MIN24, SMP_MAX24));
        one_out = {LANES{SMP_MIN24}};
        one_out[3] = SMP_MAX24;
        send_frame(one_out);
        one_out = {LANES{SMP_MAX24}};
        one_out[6] = SMP_MIN24;
        send_frame(one_out);
        send_frame(lanes_of(24'sd5, -24'sd2));
        send_frame(lanes_of(24'sd1, 24'sd0));

        // count below two, inactive lanes carry junk
        write_reg(REG_SAMPLE_FORMAT, 4'd0);
        write_reg(REG_CHANNEL_COUNT, 4'd0);
        send_frame(lanes_of(24'sh012345, -24'sd7));
        send_frame(lanes_of(-24'sd1, 24'sd2));
        write_reg(REG_CHANNEL_COUNT, 4'd1);
        send_frame(lanes_of(SMP_MIN24, 24'sd100));

        // count above the lane limit
        write_reg(REG_SAMPLE_FORMAT, 4'd1);
        write_reg(REG_CHANNEL_COUNT, 4'd15);
        send_frame(lanes_of(SMP_MAX24, SMP_MIN24));
        send_frame(lanes_of(24'sd7, -24'sd7));
        write_reg(REG_SAMPLE_FORMAT, 4'd14);
        write_reg(REG_CHANNEL_COUNT, 4'd9);
        send_frame(lanes_of(SMP_MIN24, 24'sd100));

        // random frames, one register setting per phase, bursts now and then
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_CHANNEL_COUNT, count_plan[p]);
            write_reg(REG_SAMPLE_FORMAT, format_plan[p]);
            for (int k = 0; k < PHASE_FRAMES; k++) begin
                if ($urandom_range(0, 15) == 0) begin
                    burst = !burst;
                end
                send_frame(rand_frame());
            end
        end

        wait_idle();
        if (pending != 0) begin
            $error("%0d frames never produced a result", pending);
        end
        if (mismatch_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[channel_mean_subtract.f]
rtl/cms_pkg.sv
rtl/channel_mean_subtract.sv
bench/mean_subtract_checker.sv
bench/tb.sv
